@@ rtl/sfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer and smoother.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int HIST_LEN = 11;

	localparam logic [7:0] BYTE_START = 8'h41;
	localparam logic [7:0] BYTE_END   = 8'h40;

	localparam logic [16:0] FACTOR_RESET = 17'd19661;
	localparam logic [16:0] FACTOR_ONE   = 17'd65536;

	// round(count*360*65536/4095) == floor((count*2^19 + 45) / 91)
	//   == count*5761 + floor((count*37 + 45) / 91)
	// the last quotient is (x * ceil(2^29/91)) >> 29, exact for x < 2^22
	localparam logic [12:0] ANGLE_WHOLE = 13'd5761;
	localparam logic [5:0]  ANGLE_FRAC  = 6'd37;
	localparam logic [21:0] ANGLE_BIAS  = 22'd45;
	localparam logic [22:0] ANGLE_RECIP = 23'd5899681;
	localparam int          RECIP_SHIFT = 29;

	typedef struct packed {
		logic [15:0] count;
		logic [31:0] speed_bits;
		logic [31:0] angle_bits;
	} frame_t;

endpackage : sfd_pkg
`default_nettype wire

@@ rtl/sfd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels: received bytes in, smoothed results out.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface : sfd_byte_if

interface sfd_result_if;
	logic               valid;
	logic               ready;
	logic        [28:0] encoder_angle_avg;
	logic signed [31:0] wind_speed_avg;
	logic signed [31:0] wind_angle_avg;
	logic        [15:0] raw_count;
	logic               float_saturated;

	modport source (output valid, output encoder_angle_avg, output wind_speed_avg,
		output wind_angle_avg, output raw_count, output float_saturated, input ready);
	modport sink   (input valid, input encoder_angle_avg, input wind_speed_avg,
		input wind_angle_avg, input raw_count, input float_saturated, output ready);
endinterface : sfd_result_if
`default_nettype wire

@@ rtl/sfd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_front
// Sliding byte window and frame detection; pushes frame records to the queue.
// ----------------------------------------------------------------------------
module sfd_front
	import sfd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	sfd_byte_if.sink       rx,
	output frame_t         push_data,
	output logic           push_valid,
	input  wire logic      push_ready
);

	logic [7:0] hist_q [HIST_LEN];
	logic       match;

	assign rx.ready  = push_ready;
	assign match     = (rx.rx_byte == BYTE_END) && (hist_q[HIST_LEN-1] == BYTE_START);
	assign push_valid = rx.valid && match;

	assign push_data.count      = {hist_q[9], hist_q[8]};
	assign push_data.speed_bits = {hist_q[7], hist_q[6], hist_q[5], hist_q[4]};
	assign push_data.angle_bits = {hist_q[3], hist_q[2], hist_q[1], hist_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				hist_q[i] <= 8'h00;
			end
		end else if (rx.valid && rx.ready) begin
			for (int i = HIST_LEN - 1; i > 0; i--) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= rx.rx_byte;
		end
	end

endmodule : sfd_front
`default_nettype wire

@@ rtl/sfd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_queue
// Small frame queue between the detector and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module sfd_queue
	import sfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire frame_t push_data,
	input  wire logic   push_valid,
	output logic        push_ready,
	output frame_t      pop_data,
	output logic        pop_valid,
	input  wire logic   pop_ready
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	frame_t          mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (fill_q != (PW+1)'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule : sfd_queue
`default_nettype wire

@@ rtl/sfd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_back
// Frame arithmetic: angle scaling by reciprocal multiplication, float to
// Q16.16, three moving averages on one shared multiplier, registered result.
// ----------------------------------------------------------------------------
module sfd_back
	import sfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [16:0]  factor,
	input  wire frame_t       pop_data,
	input  wire logic         pop_valid,
	output logic              pop_ready,
	sfd_result_if.source      res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FRAC  = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} conv_t;

	function automatic conv_t to_q16(input logic [31:0] bits);
		logic        neg;
		logic [7:0]  ex;
		logic [23:0] sig;
		logic [32:0] mag;
		logic [7:0]  k;
		conv_t       r;
		begin
			neg = bits[31];
			ex  = bits[30:23];
			sig = {1'b1, bits[22:0]};
			r   = '0;
			mag = '0;
			k   = '0;
			if (ex == 8'hFF) begin
				r.sat = 1'b1;
				if (bits[22:0] != '0) begin
					r.value = 32'h0000_0000;
				end else begin
					r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end
			end else begin
				if (ex == 8'h00) begin
					mag = '0;
				end else if (ex >= 8'd134) begin
					k = ex - 8'd134;
					if (k > 8'd8) begin
						mag = 33'h1_0000_0000;
					end else begin
						mag = {9'b0, sig} << k[3:0];
					end
				end else begin
					k = 8'd134 - ex;
					if (k >= 8'd24) begin
						mag = '0;
					end else begin
						mag = {9'b0, sig} >> k[4:0];
					end
				end
				if (neg) begin
					if (mag > 33'h0_8000_0000) begin
						r.sat   = 1'b1;
						r.value = 32'h8000_0000;
					end else begin
						r.value = (~mag[31:0]) + 32'd1;
					end
				end else begin
					if (mag > 33'h0_7FFF_FFFF) begin
						r.sat   = 1'b1;
						r.value = 32'h7FFF_FFFF;
					end else begin
						r.value = mag[31:0];
					end
				end
			end
			to_q16 = r;
		end
	endfunction

	logic [2:0]            state_q;
	logic [1:0]            lane_q;
	logic [21:0]           frac_q;
	logic [28:0]           enc_smp_q;
	logic [15:0]           count_q;
	logic [31:0]           spd_q;
	logic [31:0]           ang_q;
	logic                  sat_q;
	logic [31:0]           enc_state_q;
	logic [31:0]           spd_state_q;
	logic [31:0]           ang_state_q;
	logic signed [51:0]    prod_q;
	logic                  out_valid_q;
	logic [28:0]           out_enc_q;
	logic [31:0]           out_spd_q;
	logic [31:0]           out_ang_q;
	logic [15:0]           out_cnt_q;
	logic                  out_sat_q;

	conv_t                 spd_conv;
	conv_t                 ang_conv;
	logic [21:0]           frac_sum;
	logic [44:0]           recip_prod;
	logic [15:0]           frac_quot;
	logic [28:0]           enc_sample;
	logic [16:0]           fac_clamped;
	logic signed [33:0]    x_sel;
	logic signed [33:0]    s_sel;
	logic signed [33:0]    diff;
	logic [31:0]           s_new;
	logic                  out_load;

	assign spd_conv = to_q16(pop_data.speed_bits);
	assign ang_conv = to_q16(pop_data.angle_bits);

	assign frac_sum   = ({6'd0, count_q} * 22'(ANGLE_FRAC)) + ANGLE_BIAS;
	assign recip_prod = {23'd0, frac_q} * {22'd0, ANGLE_RECIP};
	assign frac_quot  = recip_prod[RECIP_SHIFT +: 16];
	assign enc_sample = ({13'd0, count_q} * {16'd0, ANGLE_WHOLE}) + {13'd0, frac_quot};

	assign fac_clamped = (factor > FACTOR_ONE) ? FACTOR_ONE : factor;

	always_comb begin
		case (lane_q)
			2'd0: begin
				x_sel = {5'b0, enc_smp_q};
				s_sel = {2'b0, enc_state_q};
			end
			2'd1: begin
				x_sel = {{2{spd_q[31]}}, spd_q};
				s_sel = {{2{spd_state_q[31]}}, spd_state_q};
			end
			default: begin
				x_sel = {{2{ang_q[31]}}, ang_q};
				s_sel = {{2{ang_state_q[31]}}, ang_state_q};
			end
		endcase
	end

	assign diff  = x_sel - s_sel;
	assign s_new = s_sel[31:0] + prod_q[47:16];

	assign pop_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	assign res.valid             = out_valid_q;
	assign res.encoder_angle_avg = out_enc_q;
	assign res.wind_speed_avg    = out_spd_q;
	assign res.wind_angle_avg    = out_ang_q;
	assign res.raw_count         = out_cnt_q;
	assign res.float_saturated   = out_sat_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				count_q <= pop_data.count;
				spd_q   <= spd_conv.value;
				ang_q   <= ang_conv.value;
				sat_q   <= spd_conv.sat | ang_conv.sat;
			end
			ST_FRAC: begin
				frac_q <= frac_sum;
			end
			ST_SCALE: begin
				enc_smp_q <= enc_sample;
			end
			ST_MUL: begin
				prod_q <= diff * $signed({1'b0, fac_clamped});
			end
			ST_ADD, ST_OUT: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_enc_q <= enc_state_q[28:0];
			out_spd_q <= spd_state_q;
			out_ang_q <= ang_state_q;
			out_cnt_q <= count_q;
			out_sat_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lane_q      <= '0;
			enc_state_q <= '0;
			spd_state_q <= '0;
			ang_state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					lane_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					case (lane_q)
						2'd0:    enc_state_q <= s_new;
						2'd1:    spd_state_q <= s_new;
						default: ang_state_q <= s_new;
					endcase
					if (lane_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule : sfd_back
`default_nettype wire

@@ rtl/sensor_frame_deframer_smoother.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_deframer_smoother
// Deframes 12-byte sensor frames from a byte stream and smooths the values.
//
// rx: one received byte per transfer (valid/ready). Bytes are taken one per
//   cycle; ready drops only while the two-entry frame queue is full.
// result: one transfer per complete frame (0x41 ... 0x40) carrying the three
//   averages in Q16.16, the raw encoder count and a float saturation flag.
// cfg_we/cfg_wdata: smoothing factor in Q1.16, reset 19661; write while idle.
// From the closing byte to result valid, the frame is written to the queue,
//   taken from it in IDLE, the angle is scaled by reciprocal multiplication
//   in FRAC and SCALE, the three averages run on the shared multiplier in
//   MUL and ADD, and the result is registered in OUT.
// Frames queue while the back end works; it takes the next one only after OUT.
// Reset clears the byte window, the averages and all valid state.
// A stalled result holds in the output register; the back end waits there,
//   and once the queue fills the byte input stalls too.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_smoother
	import sfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	sfd_byte_if.sink          rx,
	sfd_result_if.source      result,
	input  wire logic         cfg_we,
	input  wire logic [16:0]  cfg_wdata
);

	logic [16:0] factor_q;
	frame_t      push_data;
	logic        push_valid;
	logic        push_ready;
	frame_t      pop_data;
	logic        pop_valid;
	logic        pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_we) begin
			factor_q <= cfg_wdata;
		end
	end

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	sfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.factor    (factor_q),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.res       (result)
	);

endmodule : sensor_frame_deframer_smoother
`default_nettype wire

@@ tb/sfd_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_frame_checker
// Watches the byte and result channels of the frame deframer/smoother. Keeps
// its own eleven-byte window, smoothing factor and three running averages,
// predicts one smoothed frame for every closing byte that completes a frame,
// and compares each result transfer field by field with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module sfd_frame_checker
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sfd_byte_if         rx,
	sfd_result_if       result,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	output int          fail_count,
	output int          frames_pending
);

	localparam longint unsigned DEG_FULL   = 360;
	localparam longint unsigned COUNT_SPAN = 4095;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] value;
	} fixed_sample_t;

	typedef struct packed {
		logic [28:0] angle_avg;
		logic [31:0] speed_avg;
		logic [31:0] dir_avg;
		logic [15:0] count;
		logic        sat;
	} smoothed_frame_t;

	logic [7:0]         window [HIST_LEN];  // [0] newest
	logic [31:0]        angle_avg;
	logic signed [31:0] speed_avg;
	logic signed [31:0] dir_avg;
	logic [16:0]        weight;
	smoothed_frame_t    smoothed_q [$];

	initial begin
		fail_count     = 0;
		frames_pending = 0;
	end

	// IEEE single to Q16.16, truncated toward zero, saturating
	function automatic fixed_sample_t fixed_from_float(input logic [31:0] raw);
		fixed_sample_t res;
		logic [7:0]    expo;
		logic [63:0]   sig;
		logic [63:0]   mag;
		logic [63:0]   neg_mag;
		int            shift;
		expo    = raw[30:23];
		sig     = {40'd0, 1'b1, raw[22:0]};
		res.sat = 1'b0;
		if (expo == 8'hFF) begin
			res.sat = 1'b1;
			if (raw[22:0] != 23'd0)
				res.value = 32'sd0;
			else
				res.value = raw[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			return res;
		end
		if (expo == 8'h00) begin
			mag = 64'd0;
		end else if (expo >= 8'd134) begin
			shift = int'(expo) - 134;
			mag   = (shift > 8) ? 64'h1_0000_0000 : (sig << shift);
		end else begin
			shift = 134 - int'(expo);
			mag   = (shift >= 24) ? 64'd0 : (sig >> shift);
		end
		if (raw[31]) begin
			if (mag > 64'h8000_0000) begin
				res.sat   = 1'b1;
				res.value = 32'sh8000_0000;
			end else begin
				neg_mag   = -mag;
				res.value = neg_mag[31:0];
			end
		end else if (mag > 64'h7FFF_FFFF) begin
			res.sat   = 1'b1;
			res.value = 32'sh7FFF_FFFF;
		end else begin
			res.value = mag[31:0];
		end
		return res;
	endfunction

	// avg + floor((sample - avg) * gain / 2^16)
	function automatic logic signed [63:0] smooth_step(input logic signed [63:0] avg,
			input logic signed [63:0] sample, input logic [16:0] gain);
		logic signed [63:0] delta;
		delta = (sample - avg) * $signed({47'd0, gain});
		return avg + (delta >>> 16);
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("%0t: mismatch on %s, got %h, expected %h", $time, field, got, want);
	endtask

	task automatic take_byte(input logic [7:0] b);
		smoothed_frame_t    exp_frame;
		fixed_sample_t      spd;
		fixed_sample_t      dir;
		logic signed [31:0] spd_val;
		logic signed [31:0] dir_val;
		logic [16:0]        gain;
		logic [15:0]        count;
		logic [63:0]        angle_sample;
		logic signed [63:0] upd;
		if (b == BYTE_END && window[10] == BYTE_START) begin
			gain    = (weight > FACTOR_ONE) ? FACTOR_ONE : weight;
			count   = {window[9], window[8]};
			spd     = fixed_from_float({window[7], window[6], window[5], window[4]});
			dir     = fixed_from_float({window[3], window[2], window[1], window[0]});
			spd_val = spd.value;
			dir_val = dir.value;
			angle_sample = (64'(count) * DEG_FULL * 64'd65536 + 64'd2047) / COUNT_SPAN;

			upd       = smooth_step($signed({32'd0, angle_avg}), $signed(angle_sample), gain);
			angle_avg = upd[31:0];
			upd       = smooth_step(speed_avg, spd_val, gain);
			speed_avg = upd[31:0];
			upd       = smooth_step(dir_avg, dir_val, gain);
			dir_avg   = upd[31:0];

			exp_frame.angle_avg = angle_avg[28:0];
			exp_frame.speed_avg = speed_avg;
			exp_frame.dir_avg   = dir_avg;
			exp_frame.count     = count;
			exp_frame.sat       = spd.sat | dir.sat;
			smoothed_q.push_back(exp_frame);
		end
		for (int i = HIST_LEN - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
	endtask

	task automatic check_result();
		smoothed_frame_t want;
		if (smoothed_q.size() == 0) begin
			report_mismatch("result transfer with no frame pending", 32'd0, 32'd0);
			return;
		end
		want = smoothed_q.pop_front();
		if (result.encoder_angle_avg !== want.angle_avg)
			report_mismatch("encoder_angle_avg", 32'(result.encoder_angle_avg),
				32'(want.angle_avg));
		if (result.wind_speed_avg !== want.speed_avg)
			report_mismatch("wind_speed_avg", result.wind_speed_avg, want.speed_avg);
		if (result.wind_angle_avg !== want.dir_avg)
			report_mismatch("wind_angle_avg", result.wind_angle_avg, want.dir_avg);
		if (result.raw_count !== want.count)
			report_mismatch("raw_count", 32'(result.raw_count), 32'(want.count));
		if (result.float_saturated !== want.sat)
			report_mismatch("float_saturated", 32'(result.float_saturated), 32'(want.sat));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (window[i])
				window[i] = 8'd0;
			angle_avg      = '0;
			speed_avg      = '0;
			dir_avg        = '0;
			weight         = FACTOR_RESET;
			smoothed_q.delete();
			frames_pending = 0;
		end else begin
			if (result.valid && result.ready)
				check_result();
			if (rx.valid && rx.ready)
				take_byte(rx.rx_byte);
			if (cfg_we)
				weight = cfg_wdata;
			frames_pending = smoothed_q.size();
		end
	end

endmodule : sfd_frame_checker

@@ tb/tb_sensor_frame_deframer_smoother.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_smoother
// Feeds the deframer/smoother a byte stream: a few hand-built frames with
// infinite, NaN, saturating, subnormal and overlapping content, then random
// phases of mostly well-formed frames mixed with corrupted frames and noise,
// under several smoothing factors. Both channels idle at random; one phase
// runs without idling and one holds the result side off long enough to
// stall the byte input. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_smoother;
	import sfd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 500;
	localparam int PHASE_ITEMS   = 205;
	localparam int PHASE_COUNT   = 8;
	localparam int IDLE_PCT      = 11;

	localparam logic [31:0] FLT_POS_INF  = 32'h7F80_0000;
	localparam logic [31:0] FLT_QNAN     = 32'h7FC0_0001;
	localparam logic [31:0] FLT_ZERO     = 32'h0000_0000;
	localparam logic [31:0] FLT_TINY     = 32'h0001_407E;
	localparam logic [15:0] OVERLAP_CNT  = 16'hCF00;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	int          fail_count;
	int          frames_pending;
	int          cycles        = 0;
	int          items_sent    = 0;
	int          src_idle_pct  = IDLE_PCT;
	int          sink_idle_pct = IDLE_PCT;
	bit          hold_req      = 1'b0;

	sfd_byte_if   rx_if ();
	sfd_result_if res_if ();

	sensor_frame_deframer_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sfd_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx_if),
		.result         (res_if),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.frames_pending (frames_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					res_if.ready <= 1'b0;
					@(negedge clk);
				end
			end
			res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic logic [31:0] pick_float();
		logic [31:0] limit_pats [7] = '{32'h4700_0000, 32'hC700_0000, 32'h46FF_FFFF,
			32'hC6FF_FFFF, 32'h4F80_0000, 32'h3780_0000, 32'hB77F_FFFF};
		case ($urandom_range(9))
			0: return $urandom;
			1: return {1'($urandom_range(1)), 8'hFF, 23'd0};
			2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(23'h7FFFFF, 1))};
			3: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
			4: return limit_pats[$urandom_range(6)];
			default: return {1'($urandom_range(1)), 8'($urandom_range(150, 100)),
				23'($urandom)};
		endcase
	endfunction

	function automatic logic [15:0] pick_count();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one byte transfer; returns at a falling edge with the next byte not yet driven
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] count, input logic [31:0] spd,
			input logic [31:0] dir, input bit corrupt);
		logic [95:0] frame_bytes;
		int          pos;
		frame_bytes = {BYTE_START, count, spd, dir, BYTE_END};
		if (corrupt) begin
			pos = $urandom_range(11);
			frame_bytes[8*pos +: 8] = 8'($urandom);
		end
		for (int i = 11; i >= 0; i--)
			send_byte(frame_bytes[8*i +: 8]);
	endtask

	task automatic send_random_chunk();
		int         pick;
		logic [7:0] noise;
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_frame(pick_count(), pick_float(), pick_float(), 1'b0);
		end else if (pick < 85) begin
			send_frame(pick_count(), pick_float(), pick_float(), 1'b1);
		end else begin
			repeat ($urandom_range(6, 1)) begin
				case ($urandom_range(3))
					0: noise = BYTE_START;
					1: noise = BYTE_END;
					default: noise = 8'($urandom);
				endcase
				send_byte(noise);
			end
		end
	endtask

	// stop sending until every predicted frame has come out
	task automatic drain();
		rx_if.valid <= 1'b0;
		@(negedge clk);
		while (frames_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_factor(input logic [16:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int phase_end;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'd0;
		cfg_we        = 1'b0;
		cfg_wdata     = 17'd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// max count with infinite speed and NaN angle
		send_frame(16'hFFFF, FLT_POS_INF, FLT_QNAN, 1'b0);
		// two overlapping frames: the outer one carries -2^31 and a subnormal,
		// the inner one starts at the outer count's low byte
		send_byte(BYTE_START);
		send_byte(8'h00);
		send_frame(OVERLAP_CNT, FLT_ZERO, FLT_TINY, 1'b0);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain();
			case (phase)
				1: write_factor(17'd0);
				2: write_factor(FACTOR_ONE);
				3: write_factor(17'h1FFFF);
				4: write_factor(17'd1);
				5: write_factor(17'd65535);
				6: write_factor(17'($urandom_range(131071)));
				7: write_factor(FACTOR_RESET);
				default: ;
			endcase
			src_idle_pct  = (phase == 3) ? 0 : IDLE_PCT;
			sink_idle_pct = src_idle_pct;
			if (phase == 5)
				hold_req = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_chunk();
		end

		drain();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule : tb_sensor_frame_deframer_smoother
